FILE: rtl/qtmci_pkg.sv
// shared types, register codes and tables of the quadtree morton cell index
package qtmci_pkg;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_TREE_LEVEL      = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_LEFT     = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_TOP      = 3'd2;
   localparam logic [2:0] CSR_INV_CELL_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_INV_CELL_HEIGHT = 3'd4;

   // deepest tree the grid supports (levels 0 .. MAX_LEVEL-1)
   localparam logic [3:0] MAX_LEVEL = 4'd9;

   // corner order inside a box word
   localparam int NUM_CORNER = 4;
   localparam int CORNER_LEFT   = 0;
   localparam int CORNER_TOP    = 1;
   localparam int CORNER_RIGHT  = 2;
   localparam int CORNER_BOTTOM = 3;

   typedef struct packed {
      logic [3:0]  tree_level;
      logic [31:0] origin_left;
      logic [31:0] origin_top;
      logic [31:0] inv_cell_width;
      logic [31:0] inv_cell_height;
   } cfg_type;

   // per-corner integer cell coordinate plus a below-origin flag
   typedef struct packed {
      logic [NUM_CORNER-1:0]       neg;
      logic [NUM_CORNER-1:0][31:0] coord;
   } cell_type;

   // level offset (4^d - 1) / 3, first index of depth d in the linear tree
   function automatic logic [16:0] level_offset(input logic [3:0] d);
      logic [16:0] r;
      unique case (d)
         4'd0:    r = 17'd0;
         4'd1:    r = 17'd1;
         4'd2:    r = 17'd5;
         4'd3:    r = 17'd21;
         4'd4:    r = 17'd85;
         4'd5:    r = 17'd341;
         4'd6:    r = 17'd1365;
         4'd7:    r = 17'd5461;
         4'd8:    r = 17'd21845;
         4'd9:    r = 17'd87381;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // spread 8 bits to the even positions of 16
   function automatic logic [15:0] spread8(input logic [7:0] n);
      logic [15:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[2*i] = n[i];
      end
      return r;
   endfunction

endpackage

FILE: rtl/qtmci_csr.sv
// configuration registers of the quadtree morton cell index
module qtmci_csr
   import qtmci_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   // decode one register write, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_TREE_LEVEL:      cfg_in.tree_level      = csr_wdata[3:0];
            CSR_ORIGIN_LEFT:     cfg_in.origin_left     = csr_wdata;
            CSR_ORIGIN_TOP:      cfg_in.origin_top      = csr_wdata;
            CSR_INV_CELL_WIDTH:  cfg_in.inv_cell_width  = csr_wdata;
            CSR_INV_CELL_HEIGHT: cfg_in.inv_cell_height = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tree_level      <= 4'd0;
         cfg_ff.origin_left     <= 32'd0;
         cfg_ff.origin_top      <= 32'd0;
         cfg_ff.inv_cell_width  <= 32'd65536;
         cfg_ff.inv_cell_height <= 32'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/qtmci_cell.sv
// two stages: corner minus origin, then scale by inverse cell size
module qtmci_cell
   import qtmci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [127:0] in_box,
   output logic         out_valid,
   input  logic         out_ready,
   output cell_type     out_cell
);

   logic                        v1_ff, v2_ff;
   logic                        ready1, ready2;
   logic [NUM_CORNER-1:0]       neg1_ff, neg1_in;
   logic [NUM_CORNER-1:0][31:0] mag1_ff, mag1_in;
   cell_type                    cell2_ff, cell2_in;

   assign ready2   = !v2_ff || out_ready;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: signed 33-bit difference to the origin
   always_comb begin
      logic [31:0] pos, org;
      logic [32:0] diff;
      for (int c = 0; c < NUM_CORNER; c++) begin
         pos = in_box[32*c +: 32];
         org = (c == CORNER_LEFT || c == CORNER_RIGHT) ? cfg.origin_left : cfg.origin_top;
         diff = {pos[31], pos} - {org[31], org};
         neg1_in[c] = diff[32];
         mag1_in[c] = diff[31:0];
      end
   end

   // stage 2: q16.16 times q16.16, integer part of the product
   always_comb begin
      logic [31:0] inv;
      logic [63:0] prod;
      for (int c = 0; c < NUM_CORNER; c++) begin
         inv = (c == CORNER_LEFT || c == CORNER_RIGHT) ? cfg.inv_cell_width
                                                       : cfg.inv_cell_height;
         // zero-extended operands, a 32 by 32 unsigned product
         prod = 64'(mag1_ff[c]) * 64'(inv);
         cell2_in.neg[c]   = neg1_ff[c];
         cell2_in.coord[c] = prod[63:32];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= in_valid;
         if (ready2) v2_ff <= v1_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && ready1) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (v1_ff && ready2) begin
         cell2_ff <= cell2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_cell  = cell2_ff;

endmodule

FILE: rtl/qtmci_code.sv
// two stages: range check, morton codes and depth, then linear index
module qtmci_code
   import qtmci_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  cell_type    in_cell,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [16:0] out_index,
   output logic        out_index_valid,
   output logic [3:0]  out_depth
);

   logic        v3_ff, v4_ff;
   logic        ready3, ready4;
   logic        ok3_ff, ok3_in;
   logic [15:0] rb3_ff, rb3_in;
   logic [3:0]  hi3_ff, hi3_in;
   logic [3:0]  depth3_ff, depth3_in;
   logic [16:0] index4_ff, index4_in;
   logic        ok4_ff, ok4_in;
   logic [3:0]  depth4_ff, depth4_in;

   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign in_ready = ready3;

   // stage 3: grid check, interleave, highest differing level
   always_comb begin
      logic        fit;
      logic [15:0] lt, diff;
      fit = (cfg.tree_level < MAX_LEVEL);
      for (int c = 0; c < NUM_CORNER; c++) begin
         if (in_cell.neg[c] || ((in_cell.coord[c] >> cfg.tree_level) != 32'd0)) begin
            fit = 1'b0;
         end
      end
      // spread values use even bits only, so the top bit dropped by the shift is zero
      lt = spread8(in_cell.coord[CORNER_LEFT][7:0])
         | (spread8(in_cell.coord[CORNER_TOP][7:0]) << 1);
      rb3_in = spread8(in_cell.coord[CORNER_RIGHT][7:0])
             | (spread8(in_cell.coord[CORNER_BOTTOM][7:0]) << 1);
      diff = lt ^ rb3_in;
      hi3_in = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (diff[2*i +: 2] != 2'b00) hi3_in = 4'(i + 1);
      end
      depth3_in = cfg.tree_level - hi3_in;
      ok3_in    = fit;
   end

   // stage 4: shifted code plus level offset, bounded by cell count
   always_comb begin
      logic [15:0] code;
      logic [16:0] cells;
      code      = rb3_ff >> {hi3_ff, 1'b0};
      index4_in = {1'b0, code} + level_offset(depth3_ff);
      cells     = level_offset(cfg.tree_level + 4'd1);
      ok4_in    = ok3_ff && (index4_in < cells);
      depth4_in = ok4_in ? depth3_ff : 4'd0;
      if (!ok4_in) index4_in = 17'd0;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready3) v3_ff <= in_valid;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && ready3) begin
         ok3_ff    <= ok3_in;
         rb3_ff    <= rb3_in;
         hi3_ff    <= hi3_in;
         depth3_ff <= depth3_in;
      end
      if (v3_ff && ready4) begin
         index4_ff <= index4_in;
         ok4_ff    <= ok4_in;
         depth4_ff <= depth4_in;
      end
   end

   assign out_valid       = v4_ff;
   assign out_index       = index4_ff;
   assign out_index_valid = ok4_ff;
   assign out_depth       = depth4_ff;

endmodule

FILE: rtl/quadtree_morton_cell_index_top.sv
// top level of the quadtree morton cell index
// throughput: one box word per cycle unless rsp_tready stalls, four register stages (subtract, multiply,
//   morton/depth, index) each with its own valid bit and a ready chain
// reset: synchronous, clears all valid bits and loads register defaults
//   (tree_level 0, origins 0, inverse cell sizes 1.0)
module quadtree_morton_cell_index_top
   import qtmci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // box word
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // box_left, box_top, box_right, box_bottom
   // result word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,  // cell_index[16:0], cell_depth[20:17], zero pad
   output logic [0:0]   rsp_tuser,  // index_valid
   // register writes
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   cfg_type     cfg;
   cell_type    cell_coords;
   logic        cell_valid, cell_ready;
   logic [16:0] cell_index;
   logic        index_valid;
   logic [3:0]  cell_depth;

   qtmci_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qtmci_cell u_cell (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_box    (req_tdata),
      .out_valid (cell_valid),
      .out_ready (cell_ready),
      .out_cell  (cell_coords)
   );

   qtmci_code u_code (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (cell_valid),
      .in_ready        (cell_ready),
      .in_cell         (cell_coords),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_index       (cell_index),
      .out_index_valid (index_valid),
      .out_depth       (cell_depth)
   );

   assign rsp_tdata = {3'b000, cell_depth, cell_index};
   assign rsp_tuser = index_valid;

endmodule

FILE: rtl/qtmci_checker.sv
// port-level checks of the quadtree morton cell index, bound to the top level
module qtmci_checker
   import qtmci_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // no result word in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // a rejected box reports index and depth as zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 24'd0)
      else $error("nonzero fields on invalid index");

   // a valid index lies inside the range of its depth
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[20:17] < MAX_LEVEL &&
         rsp_tdata[16:0] >= level_offset(rsp_tdata[20:17]) &&
         rsp_tdata[16:0] < level_offset(rsp_tdata[20:17] + 4'd1))
      else $error("cell index outside its depth range");

endmodule

bind quadtree_morton_cell_index_top qtmci_checker u_qtmci_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
